FILE: hw/rtl/angle_bias_kalman_filter_assert.svh
// Assertion macros for the angle and bias Kalman filter
`ifndef ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define ABKF_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Check that a condition implies another in the next cycle
`define ABKF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

FILE: hw/rtl/abkf_pkg.sv
// Package with types, constants and helpers for the angle and bias Kalman filter
`timescale 1ns / 1ps
package abkf_pkg;

   localparam int RegWidth  = 24;
   localparam int FracBits  = 24;

   localparam logic [1:0] REG_NOISE_ANGLE = 2'd0;
   localparam logic [1:0] REG_NOISE_BIAS  = 2'd1;
   localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
   localparam logic [1:0] REG_TIME_STEP   = 2'd3;

   localparam logic [23:0] RST_NOISE_ANGLE = 24'd16777;
   localparam logic [23:0] RST_NOISE_BIAS  = 24'd50332;
   localparam logic [23:0] RST_MEAS_NOISE  = 24'd503316;
   localparam logic [23:0] RST_TIME_STEP   = 24'd167772;

   typedef struct packed {
      logic signed [24:0] measured_angle;
      logic signed [31:0] gyro_rate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] corrected_rate;
   } rsp_type;

   // Divider request and result
   typedef struct packed {
      logic        start;
      logic [31:0] num_mag;
      logic [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [57:0] quo;
   } div_rsp_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      logic signed [66:0] hi;
      logic signed [66:0] lo;
      hi = 67'sd2147483647;
      lo = -67'sd2147483648;
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

FILE: hw/rtl/abkf_divider.sv
// Restoring divider, one quotient bit per cycle, rounded to nearest
`timescale 1ns / 1ps
module abkf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  abkf_pkg::div_req_type div_req,
   output abkf_pkg::div_rsp_type div_rsp
);
   import abkf_pkg::*;

   // dividend = (mag << 24) + (den >> 1), up to 57 bits
   logic [56:0] dvd_ff, dvd_in;
   logic [57:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], dvd_ff[56]} - {1'b0, den_ff};
      if (div_req.start) begin
         dvd_in  = {1'b0, div_req.num_mag, 24'd0} + {24'd0, div_req.den[32:1]};
         den_in  = div_req.den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'd57;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the partial remainder
         if (!trial[33]) begin
            rem_in = trial;
            quo_in = {quo_ff[56:0], 1'b1};
         end else begin
            rem_in = {rem_ff[32:0], dvd_ff[56]};
            quo_in = {quo_ff[56:0], 1'b0};
         end
         dvd_in = {dvd_ff[55:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

FILE: hw/rtl/angle_bias_kalman_filter.sv
// Top level of the two-state angle and gyro bias Kalman filter
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | abkf_pkg::req_type (measured_angle, gyro_rate)
//  rsp     | out | rsp_valid/rsp_stall | abkf_pkg::rsp_type (filtered_angle, corrected_rate)
//  csr     | in  | csr_write_enable    | csr_index, csr_data (24 bit)
//
// Each item uses ten multiplies on one shared 33x33 multiplier, two divisions (57 quotient
// bits each, then a hand-back step) and eight other sequencer steps. When P00 + R <= 0 the
// divisions are skipped and both gains are zero. The input is stalled from acceptance until
// the sequencer is back in idle. A finished item waits in its last step while the output
// register holds a stalled result.
// Reset clears state estimates, covariance and registers to their defaults; no clearing pass.
`timescale 1ns / 1ps
module angle_bias_kalman_filter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  abkf_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output abkf_pkg::rsp_type    rsp_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_data
);
   import abkf_pkg::*;

   `include "angle_bias_kalman_filter_assert.svh"

   // sequencer steps
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RATE  = 5'd1;   // corrected rate = gyro - bias
   localparam logic [4:0] S_ANG   = 5'd2;
   localparam logic [4:0] S_DPBB  = 5'd3;   // dt * P11
   localparam logic [4:0] S_INNER = 5'd4;
   localparam logic [4:0] S_P00   = 5'd5;
   localparam logic [4:0] S_QB    = 5'd6;
   localparam logic [4:0] S_PBB   = 5'd7;
   localparam logic [4:0] S_GAIN0 = 5'd8;
   localparam logic [4:0] S_WAIT0 = 5'd9;
   localparam logic [4:0] S_GAIN1 = 5'd10;
   localparam logic [4:0] S_WAIT1 = 5'd11;
   localparam logic [4:0] S_INNOV = 5'd12;
   localparam logic [4:0] S_CANG  = 5'd13;
   localparam logic [4:0] S_CBIAS = 5'd14;
   localparam logic [4:0] S_C00   = 5'd15;
   localparam logic [4:0] S_C01   = 5'd16;
   localparam logic [4:0] S_C10   = 5'd17;
   localparam logic [4:0] S_C11   = 5'd18;
   localparam logic [4:0] S_DONE  = 5'd19;

   logic [4:0]  state_ff, state_in;
   logic        phase_ff, phase_in;   // 0: load operands, 1: product ready
   logic [23:0] qa_ff, qb_ff, rn_ff, dt_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] rate_ff, rate_in, y_ff, y_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] dpbb_ff, dpbb_in;
   logic signed [34:0] inner_ff, inner_in;  // exact inner sum, no saturation
   logic signed [24:0] meas_ff, meas_in;
   logic signed [31:0] gyro_ff, gyro_in;
   logic signed [32:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [65:0] prod_ff;
   logic signed [42:0] prod_rnd;
   logic signed [33:0] s_val;
   logic        neg_ff, neg_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic signed [31:0] gain_q;
   logic signed [34:0] inner_full;
   logic signed [65:0] p00_lo_prod;
   logic signed [68:0] p00_sum;
   logic signed [44:0] p00_rnd;

   // shared multiplier: takes the operands as they are loaded, product registered
   always_ff @(posedge clock) begin
      prod_ff <= ma_in * mb_in;
   end
   // add 2^23 and shift by 24 (floor)
   assign prod_rnd = 43'((prod_ff + 66'sd8388608) >>> FracBits);

   assign s_val = 34'(p00_ff) + $signed({10'd0, rn_ff});

   abkf_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // saturate the unsigned quotient and apply sign
   always_comb begin
      if (div_rsp.quo > 58'h7fffffff) begin
         gain_q = neg_ff ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         gain_q = neg_ff ? -$signed(div_rsp.quo[31:0]) : $signed(div_rsp.quo[31:0]);
      end
   end

   assign inner_full = 35'(dpbb_ff) - 35'(p01_ff) - 35'(p10_ff) + $signed({11'd0, qa_ff});

   // dt * inner with inner up to 35 bits: split inner = hi*4 + lo, hi in the multiplier
   assign p00_lo_prod = 66'($signed({1'b0, dt_ff}) * $signed({1'b0, inner_ff[1:0]}));
   assign p00_sum = (69'(prod_ff) <<< 2) + 69'(p00_lo_prod) + 69'sd8388608;
   assign p00_rnd = 45'(p00_sum >>> FracBits);

   always_comb begin
      state_in = state_ff;
      phase_in = 1'b0;
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      rate_in = rate_ff; y_in = y_ff; k0_in = k0_ff; k1_in = k1_ff;
      dpbb_in = dpbb_ff; inner_in = inner_ff;
      meas_in = meas_ff; gyro_in = gyro_ff;
      ma_in = ma_ff; mb_in = mb_ff;
      neg_in = neg_ff;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      div_req = '0;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               meas_in  = req_data.measured_angle;
               gyro_in  = req_data.gyro_rate;
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            rate_in  = sat32(67'(gyro_ff) - 67'(bias_ff));
            state_in = S_ANG;
         end
         S_ANG: begin
            if (!phase_ff) begin
               ma_in = $signed({9'd0, dt_ff}); mb_in = 33'(rate_ff); phase_in = 1'b1;
            end else begin
               ang_in = sat32(67'(ang_ff) + 67'(prod_rnd));
               state_in = S_DPBB;
            end
         end
         S_DPBB: begin
            if (!phase_ff) begin
               ma_in = $signed({9'd0, dt_ff}); mb_in = 33'(p11_ff); phase_in = 1'b1;
            end else begin
               // |dt*P11| < 2^55, so after >> 24 it fits 32 bits
               dpbb_in = prod_rnd[31:0];
               state_in = S_INNER;
            end
         end
         S_INNER: begin
            inner_in = inner_full;
            state_in = S_P00;
         end
         S_P00: begin
            // high part of inner goes through the multiplier, low two bits beside it
            if (!phase_ff) begin
               ma_in = $signed({9'd0, dt_ff});
               mb_in = 33'(inner_ff[34:2]);
               phase_in = 1'b1;
            end else begin
               state_in = S_QB;
               p00_in = sat32(67'(p00_ff) + 67'(p00_rnd));
            end
         end
         S_QB: begin
            if (!phase_ff) begin
               ma_in = $signed({9'd0, qb_ff}); mb_in = $signed({9'd0, dt_ff});
               phase_in = 1'b1;
               p01_in = sat32(67'(p01_ff) - 67'(dpbb_ff));
               p10_in = sat32(67'(p10_ff) - 67'(dpbb_ff));
            end else begin
               p11_in = sat32(67'(p11_ff) + 67'(prod_rnd));
               state_in = S_PBB;
            end
         end
         S_PBB: begin
            // non-positive innovation variance: zero gains, skip both divisions
            state_in = S_GAIN0;
            if (s_val[33] || (s_val == 34'sd0)) begin
               k0_in = '0; k1_in = '0; state_in = S_INNOV;
            end
         end
         S_GAIN0: begin
            neg_in = p00_ff[31];
            div_req.start   = 1'b1;
            div_req.num_mag = p00_ff[31] ? 32'(-33'(p00_ff)) : p00_ff;
            div_req.den     = s_val[32:0];
            state_in = S_WAIT0;
         end
         S_WAIT0: begin
            if (div_rsp.done) begin
               k0_in = gain_q; state_in = S_GAIN1;
            end
         end
         S_GAIN1: begin
            neg_in = p10_ff[31];
            div_req.start   = 1'b1;
            div_req.num_mag = p10_ff[31] ? 32'(-33'(p10_ff)) : p10_ff;
            div_req.den     = s_val[32:0];
            state_in = S_WAIT1;
         end
         S_WAIT1: begin
            if (div_rsp.done) begin
               k1_in = gain_q; state_in = S_INNOV;
            end
         end
         S_INNOV: begin
            y_in = sat32(67'(meas_ff) - 67'(ang_ff));
            state_in = S_CANG;
         end
         S_CANG: begin
            if (!phase_ff) begin
               ma_in = 33'(k0_ff); mb_in = 33'(y_ff); phase_in = 1'b1;
            end else begin
               ang_in = sat32(67'(ang_ff) + 67'(prod_rnd)); state_in = S_CBIAS;
            end
         end
         S_CBIAS: begin
            if (!phase_ff) begin
               ma_in = 33'(k1_ff); mb_in = 33'(y_ff); phase_in = 1'b1;
            end else begin
               bias_in = sat32(67'(bias_ff) + 67'(prod_rnd)); state_in = S_C00;
            end
         end
         S_C00: begin
            if (!phase_ff) begin
               ma_in = 33'(k0_ff); mb_in = 33'(p00_ff); phase_in = 1'b1;
            end else begin
               p00_in = sat32(67'(p00_ff) - 67'(prod_rnd)); state_in = S_C01;
            end
         end
         S_C01: begin
            if (!phase_ff) begin
               ma_in = 33'(k0_ff); mb_in = 33'(p01_ff); phase_in = 1'b1;
            end else begin
               p01_in = sat32(67'(p01_ff) - 67'(prod_rnd)); state_in = S_C10;
            end
         end
         S_C10: begin
            if (!phase_ff) begin
               ma_in = 33'(k1_ff); mb_in = 33'(p00_ff); phase_in = 1'b1;
            end else begin
               p10_in = sat32(67'(p10_ff) - 67'(prod_rnd)); state_in = S_C11;
            end
         end
         S_C11: begin
            if (!phase_ff) begin
               ma_in = 33'(k1_ff); mb_in = 33'(p01_ff); phase_in = 1'b1;
            end else begin
               p11_in = sat32(67'(p11_ff) - 67'(prod_rnd)); state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output register to drain
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_in.filtered_angle = ang_ff;
               out_in.corrected_rate = rate_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ma_ff <= ma_in; mb_ff <= mb_in;
      rate_ff <= rate_in; y_ff <= y_in; k0_ff <= k0_in; k1_ff <= k1_in;
      dpbb_ff <= dpbb_in; inner_ff <= inner_in;
      meas_ff <= meas_in; gyro_ff <= gyro_in;
      neg_ff <= neg_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= 1'b0; out_valid_ff <= 1'b0;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
         qa_ff <= RST_NOISE_ANGLE; qb_ff <= RST_NOISE_BIAS;
         rn_ff <= RST_MEAS_NOISE;  dt_ff <= RST_TIME_STEP;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; out_valid_ff <= out_valid_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_NOISE_ANGLE: qa_ff <= csr_data;
               REG_NOISE_BIAS:  qb_ff <= csr_data;
               REG_MEAS_NOISE:  rn_ff <= csr_data;
               REG_TIME_STEP:   dt_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `ABKF_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall,
      state_ff == S_RATE, "accepted item did not start the sequence")
   `ABKF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result changed")
   `ABKF_ASSERT_IMPLY(a_div_only_in_gain, clock, reset, div_req.start,
      state_ff == S_GAIN0 || state_ff == S_GAIN1, "divider started outside gain step")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the angle and gyro bias Kalman filter
`timescale 1ns / 1ps
module testbench;
   import abkf_pkg::*;

   localparam int CycleLimit = 2000000;
   localparam int AngleMax   = 11796480;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [23:0] csr_data;

   // Mirror of the filter: registers, estimates and covariance
   longint noise_angle, noise_bias, meas_noise, dt_step;
   int     angle_est, bias_est, p00, p01, p10, p11;

   rsp_type filtered_q[$];
   int      errors;
   int      cycles;
   bit      no_idle;
   bit      hold_request;
   int      stall_left;

   angle_bias_kalman_filter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int sat_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // Exact product, then round by adding half and flooring the shift
   function automatic longint mul_round(longint a, longint b);
      longint p;
      p = a * b + (64'sd1 <<< 23);
      return p >>> 24;
   endfunction

   // Gain: (num << 24) / den, ties away from zero, saturated
   function automatic int gain_quot(longint num, longint den);
      bit neg;
      longint unsigned mag, q;
      neg = num < 0;
      mag = neg ? longint'(-num) : longint'(num);
      q = ((mag << 24) + (longint'(den) >> 1)) / longint'(den);
      if (q > 64'd2147483647) q = neg ? 64'd2147483648 : 64'd2147483647;
      return neg ? sat_word(-longint'(q)) : int'(q);
   endfunction

   function automatic rsp_type filter_step(req_type it);
      rsp_type r;
      longint  meas, gyro, s, inner;
      int      rate, y, k0, k1;
      meas = longint'(it.measured_angle);
      gyro = longint'(it.gyro_rate);
      k0 = 0;
      k1 = 0;
      // predict
      rate = sat_word(gyro - bias_est);
      angle_est = sat_word(angle_est + mul_round(dt_step, rate));
      inner = mul_round(dt_step, p11) - p01 - p10 + noise_angle;
      p00 = sat_word(p00 + mul_round(dt_step, inner));
      p01 = sat_word(p01 - mul_round(dt_step, p11));
      p10 = sat_word(p10 - mul_round(dt_step, p11));
      p11 = sat_word(p11 + mul_round(noise_bias, dt_step));
      // gains; zero when the innovation variance is not positive
      s = longint'(p00) + meas_noise;
      if (s > 0) begin
         k0 = gain_quot(p00, s);
         k1 = gain_quot(p10, s);
      end
      // correct, then shrink covariance in order, reusing updated entries
      y = sat_word(meas - angle_est);
      angle_est = sat_word(angle_est + mul_round(k0, y));
      bias_est = sat_word(bias_est + mul_round(k1, y));
      p00 = sat_word(p00 - mul_round(k0, p00));
      p01 = sat_word(p01 - mul_round(k0, p01));
      p10 = sat_word(p10 - mul_round(k1, p00));
      p11 = sat_word(p11 - mul_round(k1, p01));
      r.filtered_angle = angle_est;
      r.corrected_rate = rate;
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   // Offer one item; keep valid high when the next one follows at once
   task automatic send_item(int meas, int gyro);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.measured_angle <= meas[24:0];
      req_data.gyro_rate <= gyro;
      do @(posedge clock); while (req_stall);
      filtered_q.push_back(filter_step('{measured_angle: meas[24:0], gyro_rate: gyro}));
   endtask

   // Drop valid and wait until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write all four registers back to back while idle
   task automatic program_regs(int qa, int qb, int r, int dt);
      logic [23:0] vals [4];
      logic [1:0]  idx [4];
      vals = '{qa[23:0], qb[23:0], r[23:0], dt[23:0]};
      idx = '{REG_NOISE_ANGLE, REG_NOISE_BIAS, REG_MEAS_NOISE, REG_TIME_STEP};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      noise_angle = vals[0];
      noise_bias = vals[1];
      meas_noise = vals[2];
      dt_step = vals[3];
   endtask

   function automatic int rand_angle();
      return int'($urandom_range(0, 2 * AngleMax)) - AngleMax;
   endfunction

   // Mostly plausible rates with random content, some full-range noise
   function automatic int rand_rate();
      if ($urandom_range(0, 3) == 0) return int'($urandom);
      return int'($urandom_range(0, 32'h00ffffff)) - 32'h00800000;
   endfunction

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_q.size() == 0) begin
            report("unexpected item", rsp_data.filtered_angle, 0);
         end else begin
            want = filtered_q.pop_front();
            if (rsp_data.filtered_angle !== want.filtered_angle)
               report("filtered_angle", rsp_data.filtered_angle, want.filtered_angle);
            if (rsp_data.corrected_rate !== want.corrected_rate)
               report("corrected_rate", rsp_data.corrected_rate, want.corrected_rate);
         end
      end
   end

   // Receiver stall: random short and long stretches, plus a requested long hold
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         stall_left <= 3000;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 2) stall_left <= $urandom_range(20, 200);
         else if (r < 25) stall_left <= $urandom_range(1, 4);
         rsp_stall <= 1'b0;
      end
   end

   // Field extremes and sign patterns at the reset settings
   task automatic test_extremes();
      int meas [6] = '{0, AngleMax, -AngleMax, 1, -1, 32'h00800000};
      int gyro [6] = '{0, 32'h7fffffff, 32'h80000000, -1, 1, 32'h55555555};
      for (int i = 0; i < 6; i++) send_item(meas[i], gyro[i]);
      for (int i = 0; i < 6; i++) send_item(meas[5 - i], gyro[i]);
      drain();
   endtask

   // Zero noise and zero-length steps, then the largest time step
   task automatic test_register_extremes();
      program_regs(0, 0, 1, 0);
      for (int i = 0; i < 4; i++) send_item(rand_angle(), rand_rate());
      drain();
      program_regs(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
      for (int i = 0; i < 6; i++) send_item(AngleMax, 32'h7fffffff);
      drain();
      program_regs(24'hffffff, 0, 1, 24'hffffff);
      for (int i = 0; i < 6; i++) send_item(-AngleMax, 32'h80000000);
      drain();
   endtask

   // Random items across several register settings
   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) program_regs(RST_NOISE_ANGLE, RST_NOISE_BIAS, RST_MEAS_NOISE,
                                   RST_TIME_STEP);
         else if (ph == 7) program_regs(24'hffffff, 24'hffffff, 1, 1);
         else program_regs($urandom_range(0, 24'hffffff), $urandom_range(0, 24'hffffff),
                           $urandom_range(1, 24'hffffff),
                           ($urandom_range(0, 1) != 0) ? $urandom_range(1, 24'hffffff)
                                                       : $urandom_range(1, 24'h0fffff));
         no_idle = (ph == 3);
         for (int i = 0; i < 70; i++) send_item(rand_angle(), rand_rate());
         drain();
      end
      no_idle = 1'b0;
   endtask

   // Hold the receiver off while items keep coming, so the input stalls
   task automatic test_backpressure();
      hold_request <= 1'b1;
      no_idle = 1'b1;
      for (int i = 0; i < 12; i++) send_item(rand_angle(), rand_rate());
      no_idle = 1'b0;
      drain();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      stall_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_NOISE_ANGLE;
      csr_data = '0;
      noise_angle = RST_NOISE_ANGLE;
      noise_bias = RST_NOISE_BIAS;
      meas_noise = RST_MEAS_NOISE;
      dt_step = RST_TIME_STEP;
      {angle_est, bias_est, p00, p01, p10, p11} = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_register_extremes();
      test_backpressure();
      test_random_phases();

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
